### rtl/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg: shared types and constants of the complex arithmetic unit
// Operation and status codes, the CORDIC angle table and the pipeline depth.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int DATA_WIDTH   = 32;
  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 28;
  localparam int ANGLE_WIDTH  = 33;

  localparam logic signed [ANGLE_WIDTH-1:0] HALF_PI_Q30 = 33'sd1686629713;

  typedef enum logic [2:0] {
    MODE_ADD = 3'd0,
    MODE_SUB = 3'd1,
    MODE_DIV = 3'd2,
    MODE_MAG = 3'd3,
    MODE_ARG = 3'd4
  } mode_t;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_UNDEF = 2'd1;
  localparam status_t ST_SAT   = 2'd2;

  // Number of pipeline registers from the input stage through the output register.
  function automatic int latency(input int dw);
    int deepest;
    deepest = ((dw + 5) > (CORDIC_STEPS + 3)) ? (dw + 5) : (CORDIC_STEPS + 3);
    return deepest + 2;
  endfunction

  function automatic logic [31:0] atan_q30(input int i);
    logic [31:0] v;
    unique case (i)
      0:       v = 32'h3243F6A8;
      1:       v = 32'h1DAC6705;
      2:       v = 32'h0FADBAFC;
      3:       v = 32'h07F56EA6;
      4:       v = 32'h03FEAB76;
      5:       v = 32'h01FFD55B;
      6:       v = 32'h00FFFAAA;
      7:       v = 32'h007FFF55;
      8:       v = 32'h003FFFEA;
      9:       v = 32'h001FFFFD;
      10:      v = 32'h000FFFFF;
      11:      v = 32'h0007FFFF;
      12:      v = 32'h0003FFFF;
      13:      v = 32'h0001FFFF;
      14:      v = 32'h0000FFFF;
      15:      v = 32'h00007FFF;
      16:      v = 32'h00003FFF;
      17:      v = 32'h00001FFF;
      18:      v = 32'h00000FFF;
      19:      v = 32'h000007FF;
      20:      v = 32'h000003FF;
      21:      v = 32'h000001FF;
      22:      v = 32'h000000FF;
      23:      v = 32'h0000007F;
      24:      v = 32'h0000003F;
      25:      v = 32'h0000001F;
      26:      v = 32'h0000000F;
      27:      v = 32'h00000007;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

### rtl/cau_divider.sv
// ----------------------------------------------------------------------------
// cau_divider: pipelined complex division
// Products, sums, sign split, then one restoring quotient bit per stage for
// both parts, with saturation and a zero-divisor flag.
// ----------------------------------------------------------------------------
module cau_divider #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH,
  parameter int FRAC_BITS  = cau_pkg::FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [DATA_WIDTH-1:0] x_real,
  input  logic signed [DATA_WIDTH-1:0] x_imag,
  input  logic signed [DATA_WIDTH-1:0] y_real,
  input  logic signed [DATA_WIDTH-1:0] y_imag,
  output logic signed [DATA_WIDTH-1:0] res_real,
  output logic signed [DATA_WIDTH-1:0] res_imag,
  output cau_pkg::status_t             status
);

  localparam int DW   = DATA_WIDTH;
  localparam int W2   = 2 * DW;
  localparam int LAST = DW + 5;
  localparam int OUTS = cau_pkg::latency(DW) - 2;

  function automatic logic [DW:0] fin(input logic neg, input logic ovf,
                                      input logic [DW-1:0] q);
    logic          big;
    logic [DW-1:0] v;
    big = ovf || (q[DW-1] && (!neg || (q[DW-2:0] != '0)));
    if (big) begin
      v = neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      v = neg ? -q : q;
    end
    return {big, v};
  endfunction

  logic signed [DW-1:0] a, b, c, d;
  logic signed [W2-1:0] ac, bd, bc, ad, cc, dd;
  logic signed [W2:0]   nre, nim;
  logic [W2-1:0]        den;
  logic [W2-1:0]        mag_re, mag_im, den3;
  logic                 neg_re3, neg_im3, dz3;
  logic [W2-1:0]        low_full_re, low_full_im;

  logic [W2-1:0] rem_re [0:DW];
  logic [W2-1:0] rem_im [0:DW];
  logic [DW-1:0] low_re [0:DW];
  logic [DW-1:0] low_im [0:DW];
  logic [DW-1:0] q_re   [0:DW];
  logic [DW-1:0] q_im   [0:DW];
  logic [W2-1:0] den_s  [0:DW];
  logic          neg_re [0:DW];
  logic          neg_im [0:DW];
  logic          ovf_re [0:DW];
  logic          ovf_im [0:DW];
  logic          dz_s   [0:DW];

  logic [DW:0]          fr, fi;
  logic signed [DW-1:0] re_p [LAST:OUTS];
  logic signed [DW-1:0] im_p [LAST:OUTS];
  cau_pkg::status_t     st_p [LAST:OUTS];

  always_ff @(posedge clk) begin
    if (en) begin
      a   <= x_real;
      b   <= x_imag;
      c   <= y_real;
      d   <= y_imag;
      ac  <= W2'(a) * W2'(c);
      bd  <= W2'(b) * W2'(d);
      bc  <= W2'(b) * W2'(c);
      ad  <= W2'(a) * W2'(d);
      cc  <= W2'(c) * W2'(c);
      dd  <= W2'(d) * W2'(d);
      nre <= (W2+1)'(ac) + (W2+1)'(bd);
      nim <= (W2+1)'(bc) - (W2+1)'(ad);
      den <= $unsigned(cc) + $unsigned(dd);
      mag_re  <= W2'(nre[W2] ? -nre : nre);
      mag_im  <= W2'(nim[W2] ? -nim : nim);
      neg_re3 <= nre[W2];
      neg_im3 <= nim[W2];
      den3    <= den;
      dz3     <= (den == '0);
    end
  end

  assign low_full_re = mag_re << FRAC_BITS;
  assign low_full_im = mag_im << FRAC_BITS;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_re[0] <= mag_re >> (DW - FRAC_BITS);
      rem_im[0] <= mag_im >> (DW - FRAC_BITS);
      ovf_re[0] <= (mag_re >> (DW - FRAC_BITS)) >= den3;
      ovf_im[0] <= (mag_im >> (DW - FRAC_BITS)) >= den3;
      low_re[0] <= low_full_re[DW-1:0];
      low_im[0] <= low_full_im[DW-1:0];
      q_re[0]   <= '0;
      q_im[0]   <= '0;
      den_s[0]  <= den3;
      neg_re[0] <= neg_re3;
      neg_im[0] <= neg_im3;
      dz_s[0]   <= dz3;
    end
  end

  for (genvar j = 1; j <= DW; j++) begin : g_step
    logic [W2:0] t_re, t_im, dv;
    assign t_re = {rem_re[j-1], low_re[j-1][DW-1]};
    assign t_im = {rem_im[j-1], low_im[j-1][DW-1]};
    assign dv   = {1'b0, den_s[j-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        if (t_re >= dv) begin
          rem_re[j] <= W2'(t_re - dv);
          q_re[j]   <= {q_re[j-1][DW-2:0], 1'b1};
        end else begin
          rem_re[j] <= t_re[W2-1:0];
          q_re[j]   <= {q_re[j-1][DW-2:0], 1'b0};
        end
        if (t_im >= dv) begin
          rem_im[j] <= W2'(t_im - dv);
          q_im[j]   <= {q_im[j-1][DW-2:0], 1'b1};
        end else begin
          rem_im[j] <= t_im[W2-1:0];
          q_im[j]   <= {q_im[j-1][DW-2:0], 1'b0};
        end
        low_re[j] <= {low_re[j-1][DW-2:0], 1'b0};
        low_im[j] <= {low_im[j-1][DW-2:0], 1'b0};
        den_s[j]  <= den_s[j-1];
        neg_re[j] <= neg_re[j-1];
        neg_im[j] <= neg_im[j-1];
        ovf_re[j] <= ovf_re[j-1];
        ovf_im[j] <= ovf_im[j-1];
        dz_s[j]   <= dz_s[j-1];
      end
    end
  end

  assign fr = fin(neg_re[DW], ovf_re[DW], q_re[DW]);
  assign fi = fin(neg_im[DW], ovf_im[DW], q_im[DW]);

  always_ff @(posedge clk) begin
    if (en) begin
      if (dz_s[DW]) begin
        re_p[LAST] <= '0;
        im_p[LAST] <= '0;
        st_p[LAST] <= cau_pkg::ST_UNDEF;
      end else begin
        re_p[LAST] <= fr[DW-1:0];
        im_p[LAST] <= fi[DW-1:0];
        st_p[LAST] <= (fr[DW] || fi[DW]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end
    end
  end

  for (genvar k = LAST + 1; k <= OUTS; k++) begin : g_pad
    always_ff @(posedge clk) begin
      if (en) begin
        re_p[k] <= re_p[k-1];
        im_p[k] <= im_p[k-1];
        st_p[k] <= st_p[k-1];
      end
    end
  end

  assign res_real = re_p[OUTS];
  assign res_imag = im_p[OUTS];
  assign status   = st_p[OUTS];

endmodule

### rtl/cau_sqrt.sv
// ----------------------------------------------------------------------------
// cau_sqrt: pipelined complex magnitude
// Squares, sum, then one root bit per stage of a restoring square root,
// saturated to the signed range.
// ----------------------------------------------------------------------------
module cau_sqrt #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [DATA_WIDTH-1:0] x_real,
  input  logic signed [DATA_WIDTH-1:0] x_imag,
  output logic signed [DATA_WIDTH-1:0] mag,
  output cau_pkg::status_t             status
);

  localparam int DW   = DATA_WIDTH;
  localparam int W2   = 2 * DW;
  localparam int LAST = DW + 3;
  localparam int OUTS = cau_pkg::latency(DW) - 2;

  logic signed [DW-1:0] a, b;
  logic signed [W2-1:0] aa, bb;

  logic [W2-1:0] sh   [0:DW];
  logic [DW+1:0] rem  [0:DW];
  logic [DW-1:0] root [0:DW];

  logic signed [DW-1:0] mag_p [LAST:OUTS];
  cau_pkg::status_t     st_p  [LAST:OUTS];

  always_ff @(posedge clk) begin
    if (en) begin
      a       <= x_real;
      b       <= x_imag;
      aa      <= W2'(a) * W2'(a);
      bb      <= W2'(b) * W2'(b);
      sh[0]   <= $unsigned(aa) + $unsigned(bb);
      rem[0]  <= '0;
      root[0] <= '0;
    end
  end

  for (genvar j = 1; j <= DW; j++) begin : g_step
    logic [DW+3:0] t, trial;
    assign t     = {rem[j-1], sh[j-1][W2-1 -: 2]};
    assign trial = {2'b00, root[j-1], 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        if (t >= trial) begin
          rem[j]  <= (DW+2)'(t - trial);
          root[j] <= {root[j-1][DW-2:0], 1'b1};
        end else begin
          rem[j]  <= t[DW+1:0];
          root[j] <= {root[j-1][DW-2:0], 1'b0};
        end
        sh[j] <= sh[j-1] << 2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (root[DW][DW-1]) begin
        mag_p[LAST] <= {1'b0, {(DW-1){1'b1}}};
        st_p[LAST]  <= cau_pkg::ST_SAT;
      end else begin
        mag_p[LAST] <= root[DW];
        st_p[LAST]  <= cau_pkg::ST_OK;
      end
    end
  end

  for (genvar k = LAST + 1; k <= OUTS; k++) begin : g_pad
    always_ff @(posedge clk) begin
      if (en) begin
        mag_p[k] <= mag_p[k-1];
        st_p[k]  <= st_p[k-1];
      end
    end
  end

  assign mag    = mag_p[OUTS];
  assign status = st_p[OUTS];

endmodule

### rtl/cau_cordic.sv
// ----------------------------------------------------------------------------
// cau_cordic: pipelined CORDIC argument
// Half-plane fold, one vectoring rotation per stage, clamp, then rounding
// to the output fraction and saturation.
// ----------------------------------------------------------------------------
module cau_cordic #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH,
  parameter int FRAC_BITS  = cau_pkg::FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [DATA_WIDTH-1:0] x_real,
  input  logic signed [DATA_WIDTH-1:0] x_imag,
  output logic signed [DATA_WIDTH-1:0] angle,
  output cau_pkg::status_t             status
);

  localparam int DW   = DATA_WIDTH;
  localparam int CW   = DW + 3;
  localparam int ZW   = cau_pkg::ANGLE_WIDTH;
  localparam int RW   = ZW + 1;
  localparam int CS   = cau_pkg::CORDIC_STEPS;
  localparam int LAST = CS + 3;
  localparam int OUTS = cau_pkg::latency(DW) - 2;

  localparam logic signed [ZW-1:0] HP = cau_pkg::HALF_PI_Q30;

  logic signed [DW-1:0] a, b;

  logic signed [CW-1:0] xv [0:CS];
  logic signed [CW-1:0] yv [0:CS];
  logic signed [ZW-1:0] zv [0:CS];
  logic                 xz [0:CS];
  logic                 yz [0:CS];
  logic                 yn [0:CS];

  logic signed [ZW-1:0] zc;
  logic                 und;
  logic signed [RW-1:0] r;
  logic                 sat;
  logic [DW-1:0]        val;

  logic signed [DW-1:0] ang_p [LAST:OUTS];
  cau_pkg::status_t     st_p  [LAST:OUTS];

  always_ff @(posedge clk) begin
    if (en) begin
      a     <= x_real;
      b     <= x_imag;
      xv[0] <= a[DW-1] ? -CW'(a) : CW'(a);
      yv[0] <= a[DW-1] ? -CW'(b) : CW'(b);
      zv[0] <= '0;
      xz[0] <= (a == '0);
      yz[0] <= (b == '0);
      yn[0] <= b[DW-1];
    end
  end

  for (genvar j = 1; j <= CS; j++) begin : g_step
    localparam int SH = j - 1;
    localparam logic signed [ZW-1:0] ANG = $signed({1'b0, cau_pkg::atan_q30(j - 1)});

    always_ff @(posedge clk) begin
      if (en) begin
        if (!yv[j-1][CW-1]) begin
          xv[j] <= xv[j-1] + (yv[j-1] >>> SH);
          yv[j] <= yv[j-1] - (xv[j-1] >>> SH);
          zv[j] <= zv[j-1] + ANG;
        end else begin
          xv[j] <= xv[j-1] - (yv[j-1] >>> SH);
          yv[j] <= yv[j-1] + (xv[j-1] >>> SH);
          zv[j] <= zv[j-1] - ANG;
        end
        xz[j] <= xz[j-1];
        yz[j] <= yz[j-1];
        yn[j] <= yn[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      und <= xz[CS] && yz[CS];
      if (xz[CS]) begin
        zc <= yn[CS] ? -HP : HP;
      end else if (zv[CS] > HP) begin
        zc <= HP;
      end else if (zv[CS] < -HP) begin
        zc <= -HP;
      end else begin
        zc <= zv[CS];
      end
    end
  end

  if (FRAC_BITS < 30) begin : g_round
    localparam logic signed [RW-1:0] RND = RW'(1) <<< (29 - FRAC_BITS);
    assign r = (RW'(zc) + RND) >>> (30 - FRAC_BITS);
  end else begin : g_exact
    assign r = RW'(zc);
  end

  if (DW < RW) begin : g_sat
    assign sat = !((&r[RW-1:DW-1]) || !(|r[RW-1:DW-1]));
    assign val = sat ? (r[RW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}})
                     : r[DW-1:0];
  end else begin : g_wide
    assign sat = 1'b0;
    assign val = DW'(r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (und) begin
        ang_p[LAST] <= '0;
        st_p[LAST]  <= cau_pkg::ST_UNDEF;
      end else begin
        ang_p[LAST] <= val;
        st_p[LAST]  <= sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end
    end
  end

  for (genvar k = LAST + 1; k <= OUTS; k++) begin : g_pad
    always_ff @(posedge clk) begin
      if (en) begin
        ang_p[k] <= ang_p[k-1];
        st_p[k]  <= st_p[k-1];
      end
    end
  end

  assign angle  = ang_p[OUTS];
  assign status = st_p[OUTS];

endmodule

### rtl/complex_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// complex_arithmetic_unit: pipelined complex arithmetic on signed fixed point
// Add, subtract, divide, magnitude and argument selected per beat by mode.
// ----------------------------------------------------------------------------
// Input channel: mode and the two operands travel with in_valid; a beat is
// taken at a rising edge with in_valid high and in_stall low.
// Output channel: res_real, res_imag and status travel with out_valid; a beat
// leaves at a rising edge with out_valid high and out_stall low.
// Every input beat gives exactly one output beat, in order.
// The pipeline depth is set by the divider, which resolves one quotient bit
// per stage, and by the 28 CORDIC stages.
// Throughput: one beat per cycle while in_stall is low.
// All units run in lockstep on one shared advance; a skid register behind
// the output register catches one beat when the receiver stalls, and
// in_stall rises only while that skid register is full.
// Reset (rst, synchronous) empties the pipeline, the output and skid
// registers; the first beat can be taken in the cycle after reset.
// Status: 0 ok, 1 zero divisor or undefined angle, 2 saturated.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH,
  parameter int FRAC_BITS  = cau_pkg::FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [2:0]                   mode,
  input  logic signed [DATA_WIDTH-1:0] x_real,
  input  logic signed [DATA_WIDTH-1:0] x_imag,
  input  logic signed [DATA_WIDTH-1:0] y_real,
  input  logic signed [DATA_WIDTH-1:0] y_imag,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] res_real,
  output logic signed [DATA_WIDTH-1:0] res_imag,
  output cau_pkg::status_t             status
);

  localparam int DW    = DATA_WIDTH;
  localparam int LASTP = cau_pkg::latency(DW) - 2;

  function automatic logic [DW:0] sat_sum(input logic signed [DW:0] s);
    logic          big;
    logic [DW-1:0] v;
    big = (s[DW] != s[DW-1]);
    if (big) begin
      v = s[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      v = s[DW-1:0];
    end
    return {big, v};
  endfunction

  logic                 adv;
  logic [LASTP:0]       valid;
  logic [2:0]           mode_p [0:LASTP];

  logic signed [DW-1:0] a, b, c, d;
  logic signed [DW:0]   sre, sim;
  logic [DW:0]          fre, fim;
  logic signed [DW-1:0] add_re [1:LASTP];
  logic signed [DW-1:0] add_im [1:LASTP];
  cau_pkg::status_t     add_st [1:LASTP];

  logic signed [DW-1:0] div_re, div_im, mag_re, arg_re;
  cau_pkg::status_t     div_st, mag_st, arg_st;

  logic signed [DW-1:0] sel_re, sel_im;
  cau_pkg::status_t     sel_st;

  logic                 skid_valid;
  logic signed [DW-1:0] skid_re, skid_im;
  cau_pkg::status_t     skid_st;

  assign adv      = !skid_valid;
  assign in_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (adv) begin
      valid <= {valid[LASTP-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mode_p[0] <= mode;
      a         <= x_real;
      b         <= x_imag;
      c         <= y_real;
      d         <= y_imag;
    end
  end

  for (genvar k = 1; k <= LASTP; k++) begin : g_mode
    always_ff @(posedge clk) begin
      if (adv) begin
        mode_p[k] <= mode_p[k-1];
      end
    end
  end

  always_comb begin
    if (mode_p[0] == cau_pkg::MODE_SUB) begin
      sre = (DW+1)'(a) - (DW+1)'(c);
      sim = (DW+1)'(b) - (DW+1)'(d);
    end else begin
      sre = (DW+1)'(a) + (DW+1)'(c);
      sim = (DW+1)'(b) + (DW+1)'(d);
    end
    fre = sat_sum(sre);
    fim = sat_sum(sim);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      add_re[1] <= fre[DW-1:0];
      add_im[1] <= fim[DW-1:0];
      add_st[1] <= (fre[DW] || fim[DW]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
    end
  end

  for (genvar k = 2; k <= LASTP; k++) begin : g_add_pad
    always_ff @(posedge clk) begin
      if (adv) begin
        add_re[k] <= add_re[k-1];
        add_im[k] <= add_im[k-1];
        add_st[k] <= add_st[k-1];
      end
    end
  end

  cau_divider #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_divider (
    .clk      (clk),
    .en       (adv),
    .x_real   (x_real),
    .x_imag   (x_imag),
    .y_real   (y_real),
    .y_imag   (y_imag),
    .res_real (div_re),
    .res_imag (div_im),
    .status   (div_st)
  );

  cau_sqrt #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_sqrt (
    .clk    (clk),
    .en     (adv),
    .x_real (x_real),
    .x_imag (x_imag),
    .mag    (mag_re),
    .status (mag_st)
  );

  cau_cordic #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_cordic (
    .clk    (clk),
    .en     (adv),
    .x_real (x_real),
    .x_imag (x_imag),
    .angle  (arg_re),
    .status (arg_st)
  );

  always_comb begin
    unique case (mode_p[LASTP])
      cau_pkg::MODE_ADD, cau_pkg::MODE_SUB: begin
        sel_re = add_re[LASTP];
        sel_im = add_im[LASTP];
        sel_st = add_st[LASTP];
      end
      cau_pkg::MODE_DIV: begin
        sel_re = div_re;
        sel_im = div_im;
        sel_st = div_st;
      end
      cau_pkg::MODE_MAG: begin
        sel_re = mag_re;
        sel_im = '0;
        sel_st = mag_st;
      end
      cau_pkg::MODE_ARG: begin
        sel_re = arg_re;
        sel_im = '0;
        sel_st = arg_st;
      end
      default: begin
        sel_re = '0;
        sel_im = '0;
        sel_st = cau_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= valid[LASTP];
      end
    end else if (!skid_valid && valid[LASTP]) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        res_real <= skid_re;
        res_imag <= skid_im;
        status   <= skid_st;
      end else begin
        res_real <= sel_re;
        res_imag <= sel_im;
        status   <= sel_st;
      end
    end
    if (out_valid && out_stall && !skid_valid) begin
      skid_re <= sel_re;
      skid_im <= sel_im;
      skid_st <= sel_st;
    end
  end

`ifndef SYNTH
  a_stall_needs_out : assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("skid full without a held output beat");

  a_status_code : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == cau_pkg::ST_OK || status == cau_pkg::ST_UNDEF ||
                   status == cau_pkg::ST_SAT))
    else $error("status code out of range");

  a_undef_zero : assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == cau_pkg::ST_UNDEF) |-> (res_real == '0 && res_imag == '0))
    else $error("undefined result not zero");

  a_reset_empty : assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("pipeline not empty after reset");
`endif

endmodule
